FILE: hw/rtl/gwm_pkg.sv
// Package with the types, sizes and symbol codes of the glob wildcard matcher.
package gwm_pkg;

  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned LiveW = PATTERN_MAX + 1;
  localparam int unsigned LenW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam logic [7:0] SymStar = 8'h2A;
  localparam logic [7:0] SymAny = 8'h3F;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] symbol;
  } in_beat_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } out_beat_t;

  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] bytes;
    logic [LenW-1:0]             length;
    logic                        dropped;
  } pattern_t;

endpackage

FILE: hw/rtl/gwm_pattern_store.sv
// Pattern byte storage with its length and overflow flag.
module gwm_pattern_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  gwm_pkg::in_beat_t beat_i,
  output gwm_pkg::pattern_t pattern_o
);

  logic [gwm_pkg::PATTERN_MAX-1:0][7:0] bytes_q;
  logic [gwm_pkg::LenW-1:0]             length_q, length_d;
  logic                                 dropped_q, dropped_d;
  logic                                 full;
  logic                                 write_en;

  assign full = (length_q == gwm_pkg::LenW'(gwm_pkg::PATTERN_MAX));
  assign write_en = fire_i && (beat_i.kind == gwm_pkg::KIND_APPEND) && !full;

  always_comb begin
    length_d  = length_q;
    dropped_d = dropped_q;
    if (fire_i) begin
      case (beat_i.kind)
        gwm_pkg::KIND_CLEAR: begin
          length_d  = '0;
          dropped_d = 1'b0;
        end
        gwm_pkg::KIND_APPEND: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            length_d = length_q + gwm_pkg::LenW'(1);
          end
        end
        default: begin
          length_d  = length_q;
          dropped_d = dropped_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q  <= '0;
      dropped_q <= 1'b0;
    end else begin
      length_q  <= length_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) begin
      bytes_q[length_q[gwm_pkg::IdxW-1:0]] <= beat_i.symbol;
    end
  end

  assign pattern_o.bytes   = bytes_q;
  assign pattern_o.length  = length_q;
  assign pattern_o.dropped = dropped_q;

endmodule

FILE: hw/rtl/gwm_live_update.sv
// Live pattern position vector with its star closure and per-byte advance.
module gwm_live_update (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  gwm_pkg::in_beat_t beat_i,
  input  gwm_pkg::pattern_t pattern_i,
  output logic              hit_o
);

  logic [gwm_pkg::LiveW-1:0]       live_q, live_d;
  logic [gwm_pkg::LiveW-1:0]       star_mask;
  logic [gwm_pkg::LiveW-1:0]       star_sum;
  logic [gwm_pkg::LiveW-1:0]       closed;
  logic [gwm_pkg::LiveW-1:0]       advanced;
  logic [gwm_pkg::PATTERN_MAX-1:0] in_range;
  logic [gwm_pkg::PATTERN_MAX-1:0] stay;
  logic [gwm_pkg::PATTERN_MAX-1:0] step;

  always_comb begin
    star_mask = '0;
    for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
      in_range[i]  = (gwm_pkg::LenW'(i) < pattern_i.length);
      star_mask[i] = in_range[i] && (pattern_i.bytes[i] == gwm_pkg::SymStar);
    end
  end

  // A carry started at a live star runs through the rest of its star run.
  assign star_sum = star_mask + (live_q & star_mask);
  assign closed   = live_q | (star_mask ^ star_sum);

  always_comb begin
    for (int i = 0; i < gwm_pkg::PATTERN_MAX; i++) begin
      stay[i] = closed[i] && star_mask[i];
      step[i] = closed[i] && in_range[i] && !star_mask[i] &&
                ((pattern_i.bytes[i] == beat_i.symbol) ||
                 (pattern_i.bytes[i] == gwm_pkg::SymAny));
    end
    advanced = {step, 1'b0} | {1'b0, stay};
  end

  always_comb begin
    live_d = live_q;
    if (fire_i) begin
      case (beat_i.kind)
        gwm_pkg::KIND_TEXT: live_d = advanced;
        default:            live_d = gwm_pkg::LiveW'(1);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= gwm_pkg::LiveW'(1);
    end else begin
      live_q <= live_d;
    end
  end

  assign hit_o = closed[pattern_i.length] && !pattern_i.dropped;

endmodule

FILE: hw/rtl/glob_wildcard_matcher.sv
// Top level of the glob wildcard matcher with its input and result registers.
// Glob matcher for streamed text: clear and append beats build a pattern of up to
// PATTERN_MAX bytes, in which '*' matches any run and '?' any single byte; text beats
// advance a vector of live pattern positions in one step, and an end beat returns a
// result beat with matched and overflow, then re-arms for the next text. Each beat is
// handled in the stage after the input register, so one beat is accepted per cycle
// while the input does not stall; an end beat passes from the input register to the
// result register. The input stalls only while an end beat waits behind a result the
// output holds.
module glob_wildcard_matcher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gwm_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gwm_pkg::out_beat_t out_beat_o
);

  gwm_pkg::in_beat_t  beat_q;
  logic               beat_valid_q, beat_valid_d;
  gwm_pkg::out_beat_t result_q;
  logic               result_valid_q, result_valid_d;
  gwm_pkg::pattern_t  pattern;
  logic               hit;
  logic               out_blocked;
  logic               stage_fire;
  logic               in_accept;
  logic               result_load;

  assign out_blocked = result_valid_q && out_stall_i;
  assign stage_fire  = beat_valid_q && ((beat_q.kind != gwm_pkg::KIND_END) || !out_blocked);
  assign in_stall_o  = beat_valid_q && !stage_fire;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign result_load = stage_fire && (beat_q.kind == gwm_pkg::KIND_END);

  always_comb begin
    beat_valid_d = beat_valid_q;
    if (in_accept) begin
      beat_valid_d = 1'b1;
    end else if (stage_fire) begin
      beat_valid_d = 1'b0;
    end
    result_valid_d = result_valid_q;
    if (result_load) begin
      result_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      result_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_valid_q   <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      beat_valid_q   <= beat_valid_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      beat_q <= in_beat_i;
    end
    if (result_load) begin
      result_q.matched  <= hit;
      result_q.overflow <= pattern.dropped;
    end
  end

  gwm_pattern_store u_pattern_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (stage_fire),
    .beat_i    (beat_q),
    .pattern_o (pattern)
  );

  gwm_live_update u_live_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (stage_fire),
    .beat_i    (beat_q),
    .pattern_i (pattern),
    .hit_o     (hit)
  );

  assign out_valid_o = result_valid_q;
  assign out_beat_o  = result_q;

endmodule

FILE: sim/tb_glob_wildcard_matcher.sv
// Self-checking testbench of the glob wildcard matcher with a live-position predictor.
`timescale 1ns / 100ps

module tb_glob_wildcard_matcher;
  import gwm_pkg::*;

  localparam int unsigned TotalBeats = 1800;
  localparam int unsigned QuietTail = 200;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned IdleLimit = 3000;

  class glob_scoreboard;
    logic [7:0]     pat_mem [PATTERN_MAX];
    int unsigned    pat_len;
    bit             dropped;
    bit [LiveW-1:0] live;
    out_beat_t      verdicts [$];
    int unsigned    fails;
    int unsigned    beats_in;
    int unsigned    verdicts_seen;
    int unsigned    matches_seen;
    int unsigned    overflows_seen;

    function new();
      pat_len = 0;
      dropped = 1'b0;
      live = '0;
      live[0] = 1'b1;
      fails = 0;
      beats_in = 0;
      verdicts_seen = 0;
      matches_seen = 0;
      overflows_seen = 0;
    endfunction

    function void rearm();
      live = '0;
      live[0] = 1'b1;
    endfunction

    // A live position in front of a star also makes the position after it live.
    function void close_stars();
      for (int unsigned i = 0; i < pat_len; i++) begin
        if (live[i] && pat_mem[i] == SymStar) begin
          live[i+1] = 1'b1;
        end
      end
    endfunction

    function void note_input(in_beat_t b);
      bit [LiveW-1:0] nxt;
      out_beat_t      verdict;
      beats_in++;
      case (b.kind)
        KIND_CLEAR: begin
          pat_len = 0;
          dropped = 1'b0;
          rearm();
        end
        KIND_APPEND: begin
          if (pat_len < PATTERN_MAX) begin
            pat_mem[pat_len] = b.symbol;
            pat_len++;
          end else begin
            dropped = 1'b1;
          end
          rearm();
        end
        KIND_TEXT: begin
          close_stars();
          nxt = '0;
          for (int unsigned i = 0; i < pat_len; i++) begin
            if (live[i]) begin
              if (pat_mem[i] == SymStar) begin
                nxt[i] = 1'b1;
              end else if (pat_mem[i] == b.symbol || pat_mem[i] == SymAny) begin
                nxt[i+1] = 1'b1;
              end
            end
          end
          live = nxt;
        end
        default: begin
          close_stars();
          verdict.matched = live[pat_len] && !dropped;
          verdict.overflow = dropped;
          verdicts.push_back(verdict);
          rearm();
        end
      endcase
    endfunction

    function void check_result(out_beat_t r);
      out_beat_t want;
      verdicts_seen++;
      if (r.matched) matches_seen++;
      if (r.overflow) overflows_seen++;
      if (verdicts.size() == 0) begin
        $display("%0t: result beat with none expected, actual matched %0b overflow %0b",
                 $time, r.matched, r.overflow);
        fails++;
      end else begin
        want = verdicts.pop_front();
        if (r.matched !== want.matched) begin
          $display("%0t: matched mismatch, expected %0b, actual %0b",
                   $time, want.matched, r.matched);
          fails++;
        end
        if (r.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch, expected %0b, actual %0b",
                   $time, want.overflow, r.overflow);
          fails++;
        end
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_beat_o;

  glob_scoreboard sb = new();
  bit             gaps_on = 1'b1;
  bit             hold_done = 1'b0;
  int unsigned    beats_sent = 0;
  int unsigned    idle_cycles = 0;
  logic [7:0]     pat_q [$];

  glob_wildcard_matcher u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_beat_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, IdleLimit);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: short random stalls, and one long hold-off so the block backs up.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && sb.beats_in >= 300) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_beat(input kind_e k, input logic [7:0] s);
    in_beat_t b;
    b.kind = k;
    b.symbol = s;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
    beats_sent++;
  endtask

  function automatic logic [7:0] alpha_byte();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] pattern_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return SymStar;
    if (r < 40) return SymAny;
    if (r < 88) return alpha_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // One text built mostly to follow the stored pattern, with the odd wrong byte.
  task automatic send_text();
    logic [7:0] txt [$];
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 6)) txt.push_back(alpha_byte());
    end else begin
      foreach (pat_q[i]) begin
        if (pat_q[i] == SymStar) begin
          repeat ($urandom_range(0, 3)) txt.push_back(alpha_byte());
        end else if (pat_q[i] == SymAny) begin
          txt.push_back(8'($urandom_range(0, 255)));
        end else begin
          c = pat_q[i];
          case ($urandom_range(0, 29))
            0: c = c ^ 8'h20;
            1: c = 8'($urandom_range(0, 255));
            2: continue;
            default: ;
          endcase
          txt.push_back(c);
        end
      end
    end
    foreach (txt[i]) begin
      send_beat(KIND_TEXT, txt[i]);
      if ($urandom_range(0, 199) == 0) begin
        c = pattern_byte();
        pat_q.push_back(c);
        send_beat(KIND_APPEND, c);
      end
    end
    send_beat(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_random();
    int unsigned plen;
    logic [7:0]  c;
    while (beats_sent < TotalBeats) begin
      gaps_on = (beats_sent + QuietTail < TotalBeats) && ((beats_sent / 150) % 4 != 3);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          c = 8'($urandom_range(0, 255));
          send_beat(kind_e'($urandom_range(0, 3)), c);
          if (beats_sent % 2 == 0) pat_q.push_back(c);
        end
        pat_q.delete();
        send_beat(KIND_CLEAR, 8'($urandom_range(0, 255)));
      end else begin
        pat_q.delete();
        send_beat(KIND_CLEAR, 8'($urandom_range(0, 255)));
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        repeat (plen) begin
          c = pattern_byte();
          pat_q.push_back(c);
          send_beat(KIND_APPEND, c);
        end
        repeat ($urandom_range(1, 4)) send_text();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(KIND_END, 8'hFF);
    send_beat(KIND_TEXT, 8'h78);
    send_beat(KIND_END, 8'h00);
    send_beat(KIND_CLEAR, 8'hFF);
    send_beat(KIND_APPEND, 8'h61);
    send_beat(KIND_APPEND, SymStar);
    send_beat(KIND_APPEND, SymAny);
    send_beat(KIND_APPEND, 8'h00);
    send_beat(KIND_TEXT, 8'h61);
    send_beat(KIND_TEXT, 8'hFF);
    send_beat(KIND_TEXT, 8'h80);
    send_beat(KIND_TEXT, 8'h00);
    send_beat(KIND_END, 8'h55);
    send_beat(KIND_TEXT, 8'h61);
    send_beat(KIND_APPEND, 8'h5A);
    send_beat(KIND_TEXT, 8'h61);
    send_beat(KIND_TEXT, 8'h71);
    send_beat(KIND_TEXT, 8'h00);
    send_beat(KIND_TEXT, 8'h7A);
    send_beat(KIND_END, 8'hAA);
    send_beat(KIND_CLEAR, 8'h00);
    send_beat(KIND_APPEND, SymStar);
    send_beat(KIND_END, 8'h01);
    send_beat(KIND_TEXT, 8'h41);
    send_beat(KIND_END, 8'hFE);

    run_random();
    in_valid_i <= 1'b0;

    while (sb.verdicts.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d input beats; checked %0d result beats (%0d matched, %0d overflow).",
             sb.beats_in, sb.verdicts_seen, sb.matches_seen, sb.overflows_seen);
    $display("Run included a %0d-cycle result hold-off and %0d mismatches.",
             HoldCycles, sb.fails);
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: glob_wildcard_matcher.f
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_pattern_store.sv
hw/rtl/gwm_live_update.sv
hw/rtl/glob_wildcard_matcher.sv
sim/tb_glob_wildcard_matcher.sv
